// File: rtl/lru_page_buffer_controller_defines.svh
// Assertion macros for the page buffer controller.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef LRU_PAGE_BUFFER_CONTROLLER_DEFINES_SVH
`define LRU_PAGE_BUFFER_CONTROLLER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define LPBC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define LPBC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/lpbc_pkg.sv
// Shared types, codes and constants of the page buffer controller.
// No dependencies; imported by lru_page_buffer_controller and the testbench.
package lpbc_pkg;

    localparam int NUM_FRAMES   = 16;
    localparam int FRAME_W      = 4;
    localparam int MAX_PINS_DEF = 255;
    localparam int TABLE_W      = 10;
    localparam int PAGE_W       = 32;
    localparam int REQ_W        = 3;
    localparam int STATUS_W     = 3;
    localparam int IN_DATA_W    = 48;
    localparam int OUT_DATA_W   = 48;

    typedef enum logic [REQ_W-1:0] {
        REQ_GET   = 3'd0,
        REQ_REL   = 3'd1,
        REQ_DIRTY = 3'd2,
        REQ_FLUSH = 3'd3,
        REQ_CLOSE = 3'd4
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_MISS         = 3'd1,
        ST_ALL_PINNED   = 3'd2,
        ST_TABLE_PINNED = 3'd3,
        ST_BAD_RELEASE  = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_L_RD,
        S_L_CK,
        S_V_RD,
        S_V_CK,
        S_R_RD,
        S_R_CK,
        S_C_RD,
        S_C_CK,
        S_F_RD,
        S_F_CK,
        S_F_EMIT,
        S_EMIT
    } t_state;

    typedef struct packed {
        t_status              status;
        logic [FRAME_W-1:0]   frame;
        logic                 wb;
        logic [TABLE_W-1:0]   wb_tbl;
        logic [PAGE_W-1:0]    wb_page;
        logic                 rd;
        logic                 last;
    } t_result;

    typedef logic [NUM_FRAMES-1:0][FRAME_W-1:0] t_ranks;

    // Frame that currently sits at LRU position pos.
    function automatic logic [FRAME_W-1:0] frame_at(t_ranks rk, logic [FRAME_W-1:0] pos);
        logic [FRAME_W-1:0] res;
        res = '0;
        for (int j = NUM_FRAMES - 1; j >= 0; j--) begin
            if (rk[j] == pos) begin
                res = FRAME_W'(j);
            end
        end
        return res;
    endfunction

endpackage

// File: rtl/lru_page_buffer_controller.sv
// Top level of the page buffer controller: frame tags, pins and LRU replacement.
// Depends on lpbc_pkg and lru_page_buffer_controller_defines.svh.
//
//  Channel   Direction  Handshake                   Payload
//  s (in)    slave      i_s_tvalid / o_s_tready     i_s_tdata, i_s_tuser (request code)
//  m (out)   master     o_m_tvalid / i_m_tready     o_m_tdata, o_m_tuser (status), o_m_tlast
//
// Every request is worked on alone; the frame entries sit in one memory with a
// registered read, and each visited entry takes a read state and a check state.
// Release and mark dirty read a single entry; get, flush all and close table scan
// the entries in turn, and flush all and close table give one result per write-back.
// Reset is synchronous and active low; it clears all valid bits and sets the LRU
// order to frame i at position i, so the memory needs no clearing pass.
// A result waits in the output register while the next one is prepared; the scan
// stalls only when a new result is ready and that register is still held.
`include "lru_page_buffer_controller_defines.svh"

module lru_page_buffer_controller #(
    parameter int MAX_PINS = lpbc_pkg::MAX_PINS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // table_num[9:0], page_num[41:10], frame_sel[45:42], zero fill [47:46]
    input  logic [lpbc_pkg::IN_DATA_W-1:0] i_s_tdata,
    // req_type[2:0]
    input  logic [lpbc_pkg::REQ_W-1:0]    i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // frame_index[3:0], write_back[4], wb_table_num[14:5], wb_page_num[46:15],
    // read_needed[47]
    output logic [lpbc_pkg::OUT_DATA_W-1:0] o_m_tdata,
    // status[2:0]
    output logic [lpbc_pkg::STATUS_W-1:0] o_m_tuser,
    output logic                          o_m_tlast
);
    import lpbc_pkg::*;

    localparam int PIN_W = $clog2(MAX_PINS + 1);
    localparam logic [FRAME_W-1:0] LAST_IDX = FRAME_W'(NUM_FRAMES - 1);

    // One frame entry as it lives in the memory; the valid bit is held apart.
    typedef struct packed {
        logic [TABLE_W-1:0] tbl;
        logic [PAGE_W-1:0]  page;
        logic               dirty;
        logic [PIN_W-1:0]   pins;
    } t_entry;

    t_entry             mem [NUM_FRAMES];

    t_state             r_state, n_state;
    t_req               r_req;
    logic [TABLE_W-1:0] r_tid;
    logic [PAGE_W-1:0]  r_pg;
    logic [FRAME_W-1:0] r_sel;
    logic [FRAME_W-1:0] r_cnt;
    logic [FRAME_W-1:0] r_raddr;
    t_entry             r_rdata;
    logic [NUM_FRAMES-1:0] r_valid;
    t_ranks             r_rank;
    t_result            r_res;
    logic               r_ovalid;
    t_result            r_out;

    // Control from the output decode.
    logic               mem_re, mem_we;
    logic [FRAME_W-1:0] rd_addr, wr_addr;
    t_entry             wr_data;
    logic               valid_set, valid_clr;
    logic [FRAME_W-1:0] valid_idx;
    logic               mru_en;
    logic [FRAME_W-1:0] mru_frame;
    logic               res_load;
    t_result            res_val;
    logic               out_load;
    logic               cnt_clr, cnt_inc;

    // Conditions shared by the next-state and output decode.
    logic               s_accept, slot_free, scan_last;
    logic               rd_valid;
    t_entry             rd_ent;
    logic [FRAME_W-1:0] lru0;
    logic               lru0_free, lk_hit, vk_free, rel_bad, ck_busy, fl_match, fl_wb;
    logic [PIN_W-1:0]   pins_inc;

    t_result            fin_res;

    assign s_accept  = i_s_tvalid && o_s_tready;
    assign slot_free = !r_ovalid || i_m_tready;
    assign scan_last = (r_cnt == LAST_IDX);

    // An entry that is not valid reads as all zeros.
    assign rd_valid  = r_valid[r_raddr];
    assign rd_ent    = rd_valid ? r_rdata : '0;

    assign lru0      = frame_at(r_rank, '0);
    assign lru0_free = !r_valid[lru0];
    assign lk_hit    = rd_valid && (rd_ent.tbl == r_tid) && (rd_ent.page == r_pg);
    assign vk_free   = (rd_ent.pins == '0);
    assign rel_bad   = !rd_valid || (rd_ent.pins == '0);
    assign ck_busy   = rd_valid && (rd_ent.tbl == r_tid) && (rd_ent.pins != '0);
    assign fl_match  = rd_valid && ((r_req == REQ_FLUSH) || (rd_ent.tbl == r_tid));
    assign fl_wb     = fl_match && rd_ent.dirty;
    assign pins_inc  = (rd_ent.pins < PIN_W'(MAX_PINS)) ? rd_ent.pins + 1'b1 : rd_ent.pins;

    always_comb begin
        fin_res        = '0;
        fin_res.status = ST_OK;
        fin_res.last   = 1'b1;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    case (t_req'(i_s_tuser))
                        REQ_GET:   n_state = S_L_RD;
                        REQ_REL:   n_state = S_R_RD;
                        REQ_DIRTY: n_state = S_R_RD;
                        REQ_FLUSH: n_state = S_F_RD;
                        REQ_CLOSE: n_state = S_C_RD;
                        default:   n_state = S_EMIT;
                    endcase
                end
            end
            S_L_RD: n_state = S_L_CK;
            S_L_CK: begin
                if (lk_hit) begin
                    n_state = S_EMIT;
                end else if (scan_last) begin
                    n_state = lru0_free ? S_EMIT : S_V_RD;
                end else begin
                    n_state = S_L_RD;
                end
            end
            S_V_RD: n_state = S_V_CK;
            S_V_CK: n_state = (vk_free || scan_last) ? S_EMIT : S_V_RD;
            S_R_RD: n_state = S_R_CK;
            S_R_CK: n_state = S_EMIT;
            S_C_RD: n_state = S_C_CK;
            S_C_CK: begin
                if (ck_busy) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = scan_last ? S_F_RD : S_C_RD;
                end
            end
            S_F_RD: n_state = S_F_CK;
            S_F_CK: begin
                if (fl_wb) begin
                    n_state = S_F_EMIT;
                end else begin
                    n_state = scan_last ? S_EMIT : S_F_RD;
                end
            end
            S_F_EMIT: begin
                if (slot_free) begin
                    n_state = scan_last ? S_EMIT : S_F_RD;
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        mem_re    = 1'b0;
        rd_addr   = r_cnt;
        mem_we    = 1'b0;
        wr_addr   = r_raddr;
        wr_data   = rd_ent;
        valid_set = 1'b0;
        valid_clr = 1'b0;
        valid_idx = r_raddr;
        mru_en    = 1'b0;
        mru_frame = r_raddr;
        res_load  = 1'b0;
        res_val   = fin_res;
        out_load  = 1'b0;
        cnt_clr   = 1'b0;
        cnt_inc   = 1'b0;
        case (r_state)
            S_IDLE: begin
                cnt_clr = s_accept;
                // Unused request codes answer straight away.
                res_load = s_accept;
            end
            S_L_RD, S_C_RD, S_F_RD: begin
                mem_re  = 1'b1;
                rd_addr = r_cnt;
            end
            S_V_RD: begin
                mem_re  = 1'b1;
                rd_addr = frame_at(r_rank, r_cnt);
            end
            S_R_RD: begin
                mem_re  = 1'b1;
                rd_addr = r_sel;
            end
            S_L_CK: begin
                if (lk_hit) begin
                    mem_we         = 1'b1;
                    wr_data.pins   = pins_inc;
                    mru_en         = 1'b1;
                    res_load       = 1'b1;
                    res_val.status = ST_OK;
                    res_val.frame  = r_raddr;
                end else if (scan_last) begin
                    cnt_clr = 1'b1;
                    if (lru0_free) begin
                        // The LRU frame is empty: take it, no write-back.
                        mem_we         = 1'b1;
                        wr_addr        = lru0;
                        wr_data        = '{tbl: r_tid, page: r_pg, dirty: 1'b0,
                                           pins: PIN_W'(1)};
                        valid_set      = 1'b1;
                        valid_idx      = lru0;
                        mru_en         = 1'b1;
                        mru_frame      = lru0;
                        res_load       = 1'b1;
                        res_val.status = ST_MISS;
                        res_val.frame  = lru0;
                        res_val.rd     = 1'b1;
                    end
                end else begin
                    cnt_inc = 1'b1;
                end
            end
            S_V_CK: begin
                if (vk_free) begin
                    mem_we          = 1'b1;
                    wr_data         = '{tbl: r_tid, page: r_pg, dirty: 1'b0,
                                        pins: PIN_W'(1)};
                    valid_set       = 1'b1;
                    mru_en          = 1'b1;
                    res_load        = 1'b1;
                    res_val.status  = ST_MISS;
                    res_val.frame   = r_raddr;
                    res_val.wb      = rd_ent.dirty;
                    res_val.wb_tbl  = rd_ent.dirty ? rd_ent.tbl : '0;
                    res_val.wb_page = rd_ent.dirty ? rd_ent.page : '0;
                    res_val.rd      = 1'b1;
                end else if (scan_last) begin
                    res_load       = 1'b1;
                    res_val.status = ST_ALL_PINNED;
                end else begin
                    cnt_inc = 1'b1;
                end
            end
            S_R_CK: begin
                res_load      = 1'b1;
                res_val.frame = r_sel;
                if (r_req == REQ_REL) begin
                    if (rel_bad) begin
                        res_val.status = ST_BAD_RELEASE;
                    end else begin
                        mem_we       = 1'b1;
                        wr_data.pins = rd_ent.pins - 1'b1;
                    end
                end else begin
                    mem_we        = rd_valid;
                    wr_data.dirty = 1'b1;
                end
            end
            S_C_CK: begin
                if (ck_busy) begin
                    res_load       = 1'b1;
                    res_val.status = ST_TABLE_PINNED;
                    res_val.frame  = r_raddr;
                end else if (scan_last) begin
                    cnt_clr = 1'b1;
                end else begin
                    cnt_inc = 1'b1;
                end
            end
            S_F_CK: begin
                valid_clr = fl_match;
                if (fl_wb) begin
                    res_load        = 1'b1;
                    res_val.frame   = r_raddr;
                    res_val.wb      = 1'b1;
                    res_val.wb_tbl  = rd_ent.tbl;
                    res_val.wb_page = rd_ent.page;
                    res_val.last    = 1'b0;
                end else if (scan_last) begin
                    res_load = 1'b1;
                end else begin
                    cnt_inc = 1'b1;
                end
            end
            S_F_EMIT: begin
                if (slot_free) begin
                    out_load = 1'b1;
                    if (scan_last) begin
                        res_load = 1'b1;
                    end else begin
                        cnt_inc = 1'b1;
                    end
                end
            end
            S_EMIT: begin
                out_load = slot_free;
            end
            default: begin
                res_load = 1'b0;
            end
        endcase
    end

    // Frame entry memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        if (mem_re) begin
            r_rdata <= mem[rd_addr];
            r_raddr <= rd_addr;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
            for (int j = 0; j < NUM_FRAMES; j++) begin
                r_rank[j] <= FRAME_W'(j);
            end
        end else begin
            r_state <= n_state;
            if (cnt_clr) begin
                r_cnt <= '0;
            end else if (cnt_inc) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (valid_set) begin
                r_valid[valid_idx] <= 1'b1;
            end else if (valid_clr) begin
                r_valid[valid_idx] <= 1'b0;
            end
            // Move a frame to the MRU end; frames above it slide down one place.
            if (mru_en) begin
                for (int j = 0; j < NUM_FRAMES; j++) begin
                    if (FRAME_W'(j) == mru_frame) begin
                        r_rank[j] <= LAST_IDX;
                    end else if (r_rank[j] > r_rank[mru_frame]) begin
                        r_rank[j] <= r_rank[j] - 1'b1;
                    end
                end
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_req <= t_req'(i_s_tuser);
            r_tid <= i_s_tdata[9:0];
            r_pg  <= i_s_tdata[41:10];
            r_sel <= i_s_tdata[45:42];
        end
        if (res_load) begin
            r_res <= res_val;
        end
        if (out_load) begin
            r_out <= r_res;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tuser  = r_out.status;
    assign o_m_tlast  = r_out.last;
    assign o_m_tdata  = {r_out.rd, r_out.wb_page, r_out.wb_tbl, r_out.wb, r_out.frame};

    `LPBC_ASSERT_NEXT(a_leave_idle, s_accept, r_state != S_IDLE, "request accepted but idle")
    `LPBC_ASSERT_IMPL(a_out_slot, out_load, !r_ovalid || i_m_tready, "result overwritten")
    `LPBC_ASSERT_NEXT(a_mru_rank, mru_en, r_rank[$past(mru_frame)] == LAST_IDX, "MRU move lost")
    `LPBC_ASSERT_IMPL(a_we_state, mem_we,
        r_state == S_L_CK || r_state == S_V_CK || r_state == S_R_CK, "stray memory write")

endmodule

// File: tb/sv/lru_page_buffer_controller_checker.sv
// Scoreboard of the page buffer controller: watches both channels, predicts results.
// Depends on lpbc_pkg; instantiated by lru_page_buffer_controller_test.
`timescale 1ns / 100ps

module lru_page_buffer_controller_checker
    import lpbc_pkg::*;
#(
    parameter int MAX_PINS = MAX_PINS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic [REQ_W-1:0]      i_s_tuser,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [OUT_DATA_W-1:0] i_m_tdata,
    input  logic [STATUS_W-1:0]   i_m_tuser,
    input  logic                  i_m_tlast,
    output int                    o_failures,
    output int                    o_pending
);

    typedef struct {
        logic [2:0]  status;
        logic [3:0]  frame;
        logic        wb;
        logic [9:0]  wb_tbl;
        logic [31:0] wb_page;
        logic        rd;
        logic        last;
    } t_expect;

    logic        fr_valid [NUM_FRAMES];
    logic [9:0]  fr_table [NUM_FRAMES];
    logic [31:0] fr_page  [NUM_FRAMES];
    logic        fr_dirty [NUM_FRAMES];
    int          fr_pins  [NUM_FRAMES];
    int          fr_rank  [NUM_FRAMES];

    t_expect awaited_results[$];
    int      failures;

    assign o_failures = failures;
    assign o_pending  = awaited_results.size();

    task automatic push_result(input logic [2:0] st, input int fi, input logic wb,
                               input logic [9:0] wt, input logic [31:0] wp,
                               input logic rd, input logic last);
        t_expect e;
        e.status = st; e.frame = fi[3:0]; e.wb = wb; e.wb_tbl = wt;
        e.wb_page = wp; e.rd = rd; e.last = last;
        awaited_results.push_back(e);
    endtask

    function automatic void promote(input int f);
        int r;
        r = fr_rank[f];
        for (int j = 0; j < NUM_FRAMES; j++) if (fr_rank[j] > r) fr_rank[j]--;
        fr_rank[f] = NUM_FRAMES - 1;
    endfunction

    function automatic int frame_in_position(input int pos);
        for (int j = 0; j < NUM_FRAMES; j++) if (fr_rank[j] == pos) return j;
        return 0;
    endfunction

    function automatic void drop_frame(input int f);
        fr_valid[f] = 0; fr_table[f] = '0; fr_page[f] = '0;
        fr_dirty[f] = 0; fr_pins[f] = 0;
    endfunction

    task automatic write_back_frames(input logic every, input logic [9:0] tid);
        for (int f = 0; f < NUM_FRAMES; f++) begin
            if (fr_valid[f] && (every || fr_table[f] == tid)) begin
                if (fr_dirty[f])
                    push_result(ST_OK, f, 1'b1, fr_table[f], fr_page[f], 1'b0, 1'b0);
                drop_frame(f);
            end
        end
        push_result(ST_OK, 0, 0, '0, '0, 0, 1);
    endtask

    task automatic predict_request(input logic [2:0] req, input logic [IN_DATA_W-1:0] d);
        logic [9:0]  tid;
        logic [31:0] pg;
        int          sel, victim, lru;
        logic        wb;
        logic [9:0]  wt;
        logic [31:0] wp;
        tid = d[9:0]; pg = d[41:10]; sel = d[45:42];
        case (req)
            REQ_GET: begin
                for (int f = 0; f < NUM_FRAMES; f++) begin
                    if (fr_valid[f] && fr_table[f] == tid && fr_page[f] == pg) begin
                        if (fr_pins[f] < MAX_PINS) fr_pins[f]++;
                        promote(f);
                        push_result(ST_OK, f, 0, '0, '0, 0, 1);
                        return;
                    end
                end
                victim = -1;
                lru = frame_in_position(0);
                if (!fr_valid[lru]) victim = lru;
                else begin
                    for (int p = 0; p < NUM_FRAMES && victim < 0; p++)
                        if (fr_pins[frame_in_position(p)] == 0) victim = frame_in_position(p);
                end
                if (victim < 0) begin
                    push_result(ST_ALL_PINNED, 0, 0, '0, '0, 0, 1);
                    return;
                end
                wb = fr_valid[victim] && fr_dirty[victim];
                wt = wb ? fr_table[victim] : '0;
                wp = wb ? fr_page[victim] : '0;
                fr_valid[victim] = 1; fr_table[victim] = tid; fr_page[victim] = pg;
                fr_dirty[victim] = 0; fr_pins[victim] = 1;
                promote(victim);
                push_result(ST_MISS, victim, wb, wt, wp, 1, 1);
            end
            REQ_REL: begin
                if (!fr_valid[sel] || fr_pins[sel] == 0)
                    push_result(ST_BAD_RELEASE, sel, 0, '0, '0, 0, 1);
                else begin
                    fr_pins[sel]--;
                    push_result(ST_OK, sel, 0, '0, '0, 0, 1);
                end
            end
            REQ_DIRTY: begin
                if (fr_valid[sel]) fr_dirty[sel] = 1;
                push_result(ST_OK, sel, 0, '0, '0, 0, 1);
            end
            REQ_FLUSH: write_back_frames(1'b1, '0);
            REQ_CLOSE: begin
                for (int f = 0; f < NUM_FRAMES; f++) begin
                    if (fr_valid[f] && fr_table[f] == tid && fr_pins[f] > 0) begin
                        push_result(ST_TABLE_PINNED, f, 0, '0, '0, 0, 1);
                        return;
                    end
                end
                write_back_frames(1'b0, tid);
            end
            default: push_result(ST_OK, 0, 0, '0, '0, 0, 1);
        endcase
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failures++;
        end
    endtask

    always @(posedge i_clk) begin
        t_expect e;
        if (!i_rst_n) begin
            for (int f = 0; f < NUM_FRAMES; f++) begin
                drop_frame(f);
                fr_rank[f] = f;
            end
            awaited_results.delete();
            failures = 0;
        end else begin
            // The output side is checked first; a request accepted now cannot
            // have produced a result already.
            if (i_m_tvalid && i_m_tready) begin
                if (awaited_results.size() == 0) begin
                    $error("result with no request outstanding");
                    failures++;
                end else begin
                    e = awaited_results.pop_front();
                    compare_field("status", e.status, i_m_tuser);
                    compare_field("frame_index", e.frame, i_m_tdata[3:0]);
                    compare_field("write_back", e.wb, i_m_tdata[4]);
                    compare_field("wb_table_num", e.wb_tbl, i_m_tdata[14:5]);
                    compare_field("wb_page_num", e.wb_page, i_m_tdata[46:15]);
                    compare_field("read_needed", e.rd, i_m_tdata[47]);
                    compare_field("last", e.last, i_m_tlast);
                end
            end
            if (i_s_tvalid && i_s_tready) predict_request(i_s_tuser, i_s_tdata);
        end
    end

endmodule

// File: tb/sv/lru_page_buffer_controller_test.sv
// Top of the page buffer controller testbench: clock, reset, request stimulus, verdict.
// Depends on lpbc_pkg, lru_page_buffer_controller and lru_page_buffer_controller_checker.
`timescale 1ns / 100ps

module lru_page_buffer_controller_test;
    import lpbc_pkg::*;

    localparam int RANDOM_ITEMS = 76;
    localparam int WATCHDOG_LIMIT = 5000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_tvalid, s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [REQ_W-1:0]      s_tuser;
    logic                  m_tvalid, m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]   m_tuser;
    logic                  m_tlast;
    int                    failures, pending;
    int                    quiet_cycles;
    logic                  calm_phase;

    lru_page_buffer_controller uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .o_m_tdata(m_tdata), .o_m_tuser(m_tuser), .o_m_tlast(m_tlast)
    );

    lru_page_buffer_controller_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .i_m_tdata(m_tdata), .i_m_tuser(m_tuser), .i_m_tlast(m_tlast),
        .o_failures(failures), .o_pending(pending)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The receiver stalls in random bursts until the final calm stretch.
    always @(posedge i_clk) begin
        int hold;
        if (!i_rst_n || calm_phase) m_tready <= 1'b1;
        else if (hold > 0) hold--;
        else if ($urandom_range(0, 3) == 0) begin
            hold = $urandom_range(1, 10);
            m_tready <= ~m_tready;
        end else m_tready <= 1'b1;
    end

    // Watchdog: ends the run when no item moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else quiet_cycles <= quiet_cycles + 1;
    end

    // Presents one request and holds it until it is accepted; outside the calm phase
    // it then lowers valid at random for a random gap before the caller goes on.
    task automatic send_request(input logic [2:0] req, input logic [9:0] tid,
                                input logic [31:0] pg, input logic [3:0] sel);
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {2'b00, sel, pg, tid};
        do @(posedge i_clk); while (!s_tready);
        if (!calm_phase && $urandom_range(0, 2) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        logic [2:0]  req;
        logic [9:0]  tid;
        logic [31:0] pg;
        int          pick;
        i_rst_n    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        m_tready   = 1'b1;
        calm_phase = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: extremes of tag fields, hits, dirty victims, bad
        // releases, pin exhaustion, close with a pinned frame, unused codes.
        send_request(REQ_GET, 10'h3ff, 32'hffff_ffff, 4'd0);
        send_request(REQ_GET, 10'h3ff, 32'hffff_ffff, 4'd0);
        send_request(REQ_DIRTY, 0, 0, 4'd0);
        send_request(REQ_DIRTY, 0, 0, 4'd15);
        send_request(REQ_REL, 0, 0, 4'd0);
        send_request(REQ_REL, 0, 0, 4'd0);
        send_request(REQ_REL, 0, 0, 4'd0);
        send_request(REQ_REL, 0, 0, 4'd15);
        send_request(REQ_CLOSE, 10'h3ff, 0, 0);
        for (int i = 0; i < 16; i++) send_request(REQ_GET, 10'd0, i, 0);
        send_request(REQ_GET, 10'd1, 32'd99, 0);
        send_request(REQ_CLOSE, 10'd0, 0, 0);
        send_request(REQ_REL, 0, 0, 4'd3);
        send_request(REQ_DIRTY, 0, 0, 4'd3);
        send_request(REQ_GET, 10'd2, 32'd7, 0);
        send_request(3'd5, 10'h155, 32'h5555_5555, 4'd5);
        send_request(3'd7, 10'h2aa, 32'haaaa_aaaa, 4'd10);
        send_request(3'd6, 0, 0, 0);
        send_request(REQ_FLUSH, 0, 0, 0);
        // Sender waits until every expected result has come.
        drain_results();

        // Random part: mostly gets and releases over a small tag space so
        // that hits, evictions and write-backs come often.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS - 20) calm_phase = 1'b1;
            pick = $urandom_range(0, 99);
            tid  = ($urandom_range(0, 7) == 0) ? 10'($urandom) : 10'($urandom_range(0, 3));
            pg   = ($urandom_range(0, 7) == 0) ? $urandom : 32'($urandom_range(0, 7));
            if (pick < 45) req = REQ_GET;
            else if (pick < 70) req = REQ_REL;
            else if (pick < 85) req = REQ_DIRTY;
            else if (pick < 90) req = REQ_FLUSH;
            else if (pick < 97) req = REQ_CLOSE;
            else req = 3'($urandom_range(5, 7));
            send_request(req, tid, pg, 4'($urandom));
        end
        drain_results();
        repeat (80) @(posedge i_clk);

        if (failures == 0 && pending == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/lpbc_pkg.sv
rtl/lru_page_buffer_controller.sv
tb/sv/lru_page_buffer_controller_checker.sv
tb/sv/lru_page_buffer_controller_test.sv
